// ----- rtl/kmuf_pkg.sv -----
// kmuf_pkg: shared types and constants of the Kruskal maze union-find engine.
// Holds the command and result transaction structs, outcome codes, the
// sequencer state type and the configuration register map. No dependencies.
`default_nettype none

package kmuf_pkg;

	// Configuration register map
	localparam int CFG_INDEX_W = 1;
	localparam int CFG_DATA_W  = 7;
	localparam logic [CFG_INDEX_W-1:0] CFG_COLUMNS = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_ROWS    = 1'd1;

	// Grid dimension lower limit and reset value
	localparam logic [CFG_DATA_W-1:0] DIM_RESET = 7'd20;
	localparam logic [CFG_DATA_W-1:0] DIM_MIN   = 7'd4;

	// Width of the reported root index
	localparam int ROOT_W = 12;

	typedef enum logic [1:0] {
		OUT_JOINED  = 2'd0,
		OUT_WALL    = 2'd1,
		OUT_SKIPPED = 2'd2,
		OUT_CLEARED = 2'd3
	} outcome_t;

	typedef struct packed {
		logic       kind;
		logic [5:0] cell_x;
		logic [5:0] cell_y;
		logic       direction;
	} edge_cmd_t;

	typedef struct packed {
		outcome_t          outcome;
		logic [5:0]        out_x;
		logic [5:0]        out_y;
		logic              out_direction;
		logic [ROOT_W-1:0] root_index;
	} edge_res_t;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_CLEAR,
		ST_CHECK,
		ST_WALK,
		ST_COMP,
		ST_JOIN
	} state_t;

endpackage

`default_nettype wire

// ----- rtl/kruskal_maze_union_find.sv -----
// kruskal_maze_union_find: union-find engine for Kruskal maze carving; needs kmuf_pkg, kmuf_ram.
// An edge is checked against the grid (off-grid edges are skipped), then each cell's parent links
// are walked to its root and the path compressed (one RAM access a cycle), and the roots joined.
// Clear sweeps all MAX_COLUMNS*MAX_ROWS entries. Busy drops in the result cycle, so the next
// transaction is taken at the edge that ends it; the receiver cannot stall.
// Reset: the same sweep runs with busy high.
`default_nettype none

module kruskal_maze_union_find #(
	parameter int MAX_COLUMNS = 64,
	parameter int MAX_ROWS    = 64
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// command channel
	input  wire logic                                start,
	output logic                                     busy,
	input  wire kmuf_pkg::edge_cmd_t                 cmd,
	// result channel
	output logic                                     done,
	output kmuf_pkg::edge_res_t                      res,
	// configuration write channel
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [kmuf_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [kmuf_pkg::CFG_DATA_W-1:0]     cfg_data
);

	import kmuf_pkg::*;

	localparam int TABLE_SIZE = MAX_COLUMNS * MAX_ROWS;
	localparam int IDX_W      = $clog2(TABLE_SIZE);
	localparam int CW         = $clog2(MAX_COLUMNS + 1);
	localparam int RW         = $clog2(MAX_ROWS + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

	// Control registers
	state_t                  state_q, state_d;
	logic [IDX_W-1:0]        clr_q, clr_d;
	logic                    side_q, side_d;
	logic                    done_q, done_d;
	logic [CFG_DATA_W-1:0]   cols_cfg_q, rows_cfg_q;

	// Payload registers
	edge_cmd_t               cmd_q;
	logic [IDX_W-1:0]        idx_a_s1, idx_b_s1;
	logic                    in_grid_s1;
	logic [IDX_W-1:0]        cur_q, cur_d;
	logic [IDX_W-1:0]        root_q, root_d;
	logic [IDX_W-1:0]        root_a_q, root_a_d;
	edge_res_t               res_q, res_d;

	// RAM interface and forwarding
	logic                    ram_we;
	logic [IDX_W-1:0]        ram_waddr, ram_wdata, ram_raddr, ram_rdata;
	logic                    fwd_hit_q;
	logic [IDX_W-1:0]        fwd_data_q;
	logic [IDX_W-1:0]        rd_data;

	// Index arithmetic
	logic [CW-1:0]           cols_use;
	logic [RW-1:0]           rows_use;
	logic [31:0]             nx_w, ny_w;
	logic [IDX_W-1:0]        idx_a, idx_b;
	logic                    in_grid;
	logic                    accept;

	// Sequencer helpers
	logic [IDX_W-1:0]        node_sel;
	logic                    side_done;
	logic [IDX_W-1:0]        side_root;
	logic                    emit;
	outcome_t                emit_outcome;
	logic [IDX_W-1:0]        emit_root;
	logic [IDX_W+ROOT_W-1:0] root_wide;

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign res       = res_q;

	// Parent RAM
	kmuf_ram #(
		.WIDTH (IDX_W),
		.DEPTH (TABLE_SIZE)
	) u_parent_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Same-address write forwarding onto the read data
	assign rd_data = fwd_hit_q ? fwd_data_q : ram_rdata;

	// Grid size in use, saturated to the supported range
	always_comb begin
		if (cols_cfg_q < DIM_MIN) begin
			cols_use = CW'(DIM_MIN);
		end else if (32'(cols_cfg_q) > MAX_COLUMNS) begin
			cols_use = CW'(MAX_COLUMNS);
		end else begin
			cols_use = CW'(cols_cfg_q);
		end
		if (rows_cfg_q < DIM_MIN) begin
			rows_use = RW'(DIM_MIN);
		end else if (32'(rows_cfg_q) > MAX_ROWS) begin
			rows_use = RW'(MAX_ROWS);
		end else begin
			rows_use = RW'(rows_cfg_q);
		end
	end

	// Cell indices and grid check of the incoming edge
	always_comb begin
		nx_w    = 32'(cmd.cell_x) + 32'(!cmd.direction);
		ny_w    = 32'(cmd.cell_y) + 32'(cmd.direction);
		in_grid = (nx_w < 32'(cols_use)) && (ny_w < 32'(rows_use));
		idx_a   = IDX_W'(32'(cmd.cell_y) * 32'(cols_use) + 32'(cmd.cell_x));
		idx_b   = IDX_W'(32'(idx_a) + (cmd.direction ? 32'(cols_use) : 32'd1));
	end

	// Sequencer: next state, RAM control and results
	always_comb begin
		state_d      = state_q;
		clr_d        = clr_q;
		side_d       = side_q;
		done_d       = 1'b0;
		cur_d        = cur_q;
		root_d       = root_q;
		root_a_d     = root_a_q;
		res_d        = res_q;
		ram_we       = 1'b0;
		ram_waddr    = cur_q;
		ram_wdata    = root_q;
		ram_raddr    = cur_q;
		side_done    = 1'b0;
		side_root    = root_q;
		emit         = 1'b0;
		emit_outcome = OUT_SKIPPED;
		emit_root    = '0;
		node_sel     = side_q ? idx_b_s1 : idx_a_s1;

		case (state_q)
			ST_INIT, ST_CLEAR: begin
				// sweep: every cell back to its own set
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = clr_q;
				clr_d     = clr_q + 1'b1;
				if (clr_q == LAST_IDX) begin
					clr_d   = '0;
					state_d = ST_IDLE;
					if (state_q == ST_CLEAR) begin
						emit         = 1'b1;
						emit_outcome = OUT_CLEARED;
					end
				end
			end
			ST_IDLE: begin
				if (accept) begin
					clr_d   = '0;
					state_d = cmd.kind ? ST_CLEAR : ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (!in_grid_s1) begin
					emit         = 1'b1;
					emit_outcome = OUT_SKIPPED;
					state_d      = ST_IDLE;
				end else begin
					ram_raddr = idx_a_s1;
					cur_d     = idx_a_s1;
					side_d    = 1'b0;
					state_d   = ST_WALK;
				end
			end
			ST_WALK: begin
				// follow parent links up to the root
				if (rd_data >= cur_q) begin
					root_d = cur_q;
					if (node_sel == cur_q) begin
						side_done = 1'b1;
						side_root = cur_q;
					end else begin
						ram_raddr = node_sel;
						cur_d     = node_sel;
						state_d   = ST_COMP;
					end
				end else begin
					ram_raddr = rd_data;
					cur_d     = rd_data;
				end
			end
			ST_COMP: begin
				// second pass: point every node on the path at the root
				ram_we    = 1'b1;
				ram_waddr = cur_q;
				ram_wdata = root_q;
				if (rd_data == root_q) begin
					side_done = 1'b1;
					side_root = root_q;
				end else begin
					ram_raddr = rd_data;
					cur_d     = rd_data;
				end
			end
			ST_JOIN: begin
				emit    = 1'b1;
				state_d = ST_IDLE;
				if (root_a_q != root_q) begin
					ram_we       = 1'b1;
					emit_outcome = OUT_JOINED;
					if (root_a_q < root_q) begin
						ram_waddr = root_q;
						ram_wdata = root_a_q;
						emit_root = root_a_q;
					end else begin
						ram_waddr = root_a_q;
						ram_wdata = root_q;
						emit_root = root_q;
					end
				end else begin
					emit_outcome = OUT_WALL;
					emit_root    = root_a_q;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		// one root found: start the neighbour or go to the union
		if (side_done) begin
			if (!side_q) begin
				root_a_d  = side_root;
				side_d    = 1'b1;
				ram_raddr = idx_b_s1;
				cur_d     = idx_b_s1;
				state_d   = ST_WALK;
			end else begin
				root_d  = side_root;
				state_d = ST_JOIN;
			end
		end

		// result transaction
		root_wide = {{ROOT_W{1'b0}}, emit_root};
		if (emit) begin
			done_d              = 1'b1;
			res_d.outcome       = emit_outcome;
			res_d.out_x         = cmd_q.cell_x;
			res_d.out_y         = cmd_q.cell_y;
			res_d.out_direction = cmd_q.direction;
			res_d.root_index    = root_wide[ROOT_W-1:0];
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_INIT;
			clr_q     <= '0;
			side_q    <= 1'b0;
			done_q    <= 1'b0;
			fwd_hit_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			clr_q     <= clr_d;
			side_q    <= side_d;
			done_q    <= done_d;
			fwd_hit_q <= ram_we && (ram_waddr == ram_raddr);
		end
	end

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_cfg_q <= DIM_RESET;
			rows_cfg_q <= DIM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_COLUMNS: cols_cfg_q <= cfg_data;
				CFG_ROWS:    rows_cfg_q <= cfg_data;
				default:     ;
			endcase
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q      <= cmd;
			idx_a_s1   <= idx_a;
			idx_b_s1   <= idx_b;
			in_grid_s1 <= in_grid;
		end
		cur_q      <= cur_d;
		root_q     <= root_d;
		root_a_q   <= root_a_d;
		res_q      <= res_d;
		fwd_data_q <= ram_wdata;
	end

	// Assertions
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobed while the engine is busy");

	a_walk_descends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_WALK && rd_data != cur_q) |-> (rd_data < cur_q))
		else $error("parent link does not point at a smaller index");

	a_write_order: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (ram_wdata <= ram_waddr))
		else $error("parent write would break the index ordering");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted transaction did not start work");

endmodule

`default_nettype wire

// ----- rtl/kmuf_ram.sv -----
// kmuf_ram: generic simple dual-port RAM, one write port, one read port.
// Read data is registered, old data on a same-address write.
// No dependencies.
`default_nettype none

module kmuf_ram #(
	parameter int WIDTH = 12,
	parameter int DEPTH = 4096,
	localparam int AW = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire
